// ===== sv/grwi_pkg.sv =====
// Shared constants, types and tables for the grid ray / wall intersection block.
package grwi_pkg;

  localparam int MAP_SIDE_DEF  = 64;
  localparam int TILE          = 64;
  localparam int FRAC_BITS     = 8;
  localparam int TILE_SHIFT    = $clog2(TILE) + FRAC_BITS;
  localparam int TRIG_FRAC     = 16;
  localparam int ANGLE_STEPS   = 4096;
  localparam int ANG_W         = 12;
  localparam int COORD_W       = 21;
  localparam int CODE_W        = 8;
  localparam int CFG_W         = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int CORDIC_STEPS  = 24;
  localparam int CS_W          = 34;
  localparam int RATIO_W       = 28;
  localparam int WALK_W        = 30;
  localparam int PROD_W        = WALK_W + RATIO_W;

  localparam logic [CODE_W-1:0] CODE_WALL1 = 8'h31;
  localparam logic [CODE_W-1:0] CODE_WALL2 = 8'h32;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_TRIG, S_DIVT_GO, S_DIVT, S_DIVC_GO, S_DIVC,
    S_MULH, S_INITH, S_CHK, S_RD, S_MULV, S_INITV, S_DONE
  } grwi_state_e;

  // atan(2^-i) in units of a full turn / 2^32
  function automatic logic [31:0] turn_atan(input logic [4:0] i);
    case (i)
      5'd0:  turn_atan = 32'd536870912;
      5'd1:  turn_atan = 32'd316933406;
      5'd2:  turn_atan = 32'd167458907;
      5'd3:  turn_atan = 32'd85004756;
      5'd4:  turn_atan = 32'd42667331;
      5'd5:  turn_atan = 32'd21354465;
      5'd6:  turn_atan = 32'd10679838;
      5'd7:  turn_atan = 32'd5340245;
      5'd8:  turn_atan = 32'd2670163;
      5'd9:  turn_atan = 32'd1335087;
      5'd10: turn_atan = 32'd667544;
      5'd11: turn_atan = 32'd333772;
      5'd12: turn_atan = 32'd166886;
      5'd13: turn_atan = 32'd83443;
      5'd14: turn_atan = 32'd41722;
      5'd15: turn_atan = 32'd20861;
      5'd16: turn_atan = 32'd10430;
      5'd17: turn_atan = 32'd5215;
      5'd18: turn_atan = 32'd2608;
      5'd19: turn_atan = 32'd1304;
      5'd20: turn_atan = 32'd652;
      5'd21: turn_atan = 32'd326;
      5'd22: turn_atan = 32'd163;
      5'd23: turn_atan = 32'd81;
      default: turn_atan = 32'd0;
    endcase
  endfunction

endpackage

// ===== sv/grwi_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module grwi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/grwi_cordic.sv =====
// Iterative CORDIC rotator: one shift-add rotation per cycle, gives cos and sin.
module grwi_cordic import grwi_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [ANG_W-1:0]       angle_i,
  output logic                   done_o,
  output logic signed [CS_W-1:0] c_o,
  output logic signed [CS_W-1:0] s_o
);

  logic                   run_q, run_d;
  logic                   done_q, done_d;
  logic [4:0]             i_q, i_d;
  logic signed [CS_W-1:0] c_q, c_d, s_q, s_d, z_q, z_d;
  logic signed [CS_W-1:0] z0, atn;

  always_comb begin
    // turn angle a*2^32/S, folded to within a quarter turn
    z0 = $signed({{(CS_W-32){1'b0}}, angle_i, {(32-ANG_W){1'b0}}});
    if (z0 >= $signed(CS_W'(64'd3 << 30))) begin
      z0 = z0 - $signed(CS_W'(64'd1 << 32));
    end else if (z0 >= $signed(CS_W'(64'd1 << 30))) begin
      z0 = z0 - $signed(CS_W'(64'd1 << 31));
    end
    atn = $signed({{(CS_W-32){1'b0}}, turn_atan(i_q)});
    run_d  = run_q;
    done_d = 1'b0;
    i_d    = i_q;
    c_d    = c_q;
    s_d    = s_q;
    z_d    = z_q;
    if (start_i) begin
      run_d = 1'b1;
      i_d   = '0;
      c_d   = $signed(CS_W'(64'd1 << 30));
      s_d   = '0;
      z_d   = z0;
    end else if (run_q) begin
      if (z_q >= 0) begin
        c_d = c_q - (s_q >>> i_q);
        s_d = s_q + (c_q >>> i_q);
        z_d = z_q - atn;
      end else begin
        c_d = c_q + (s_q >>> i_q);
        s_d = s_q - (c_q >>> i_q);
        z_d = z_q + atn;
      end
      i_d = i_q + 5'd1;
      if (i_q == 5'(CORDIC_STEPS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      i_q    <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
    s_q <= s_d;
    z_q <= z_d;
  end

  assign done_o = done_q;
  assign c_o    = c_q;
  assign s_o    = s_q;

endmodule

// ===== sv/grwi_div.sv =====
// Restoring divider for Q.16 ratios, rounded half up and saturated; one bit a cycle.
module grwi_div import grwi_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [CS_W-1:0]    num_i,
  input  logic signed [CS_W-1:0]    den_i,
  output logic                      done_o,
  output logic signed [RATIO_W-1:0] q_o
);

  localparam int QB    = RATIO_W;          // quotient bits 27..0
  localparam int AN_W  = CS_W;
  localparam int R_W   = AN_W + TRIG_FRAC + 1;
  localparam int SH_W  = R_W + QB;
  localparam logic [RATIO_W-2:0] LIM = (RATIO_W-1)'(1) << (RATIO_W-2);

  logic            run_q, run_d, done_q, done_d;
  logic            neg_q, neg_d, sat_q, sat_d;
  logic [4:0]      k_q, k_d;
  logic [R_W-1:0]  r_q, r_d;
  logic [AN_W-1:0] d_q, d_d;
  logic [QB-1:0]   qb_q, qb_d;
  logic [AN_W-1:0] an, ad;
  logic [SH_W-1:0] dsh, trial;
  logic [RATIO_W-2:0] mag;

  always_comb begin
    an  = num_i[CS_W-1] ? AN_W'(-num_i) : AN_W'(num_i);
    ad  = den_i[CS_W-1] ? AN_W'(-den_i) : AN_W'(den_i);
    dsh = SH_W'(d_q) << k_q;
    trial = SH_W'(r_q) - dsh;
    run_d  = run_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    sat_d  = sat_q;
    k_d    = k_q;
    r_d    = r_q;
    d_d    = d_q;
    qb_d   = qb_q;
    if (start_i) begin
      run_d = 1'b1;
      neg_d = num_i[CS_W-1] ^ den_i[CS_W-1];
      sat_d = 1'b0;
      k_d   = 5'(QB - 1);
      r_d   = (R_W'(an) << TRIG_FRAC) + R_W'(ad >> 1);
      d_d   = ad;
      qb_d  = '0;
    end else if (run_q) begin
      if (SH_W'(r_q) >= dsh) begin
        r_d = trial[R_W-1:0];
        qb_d[k_q] = 1'b1;
      end
      k_d = k_q - 5'd1;
      // top bit set means the quotient is past any usable range
      if (k_q == 5'(QB - 1) && SH_W'(r_q) >= dsh) begin
        sat_d  = 1'b1;
        run_d  = 1'b0;
        done_d = 1'b1;
      end else if (k_q == 5'd0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    sat_q <= sat_d;
    r_q   <= r_d;
    d_q   <= d_d;
    qb_q  <= qb_d;
  end

  always_comb begin
    if (sat_q || qb_q > QB'(LIM)) begin
      mag = LIM;
    end else begin
      mag = qb_q[RATIO_W-2:0];
    end
    q_o = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  assign done_o = done_q;

endmodule

// ===== sv/grid_ray_wall_intersection.sv =====
// Top level of the grid ray / wall intersection block: sequencer, walk datapath, map.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+----------------------------
//  item in | func, cell_*, player_x/y, ray_angle     | start_i while busy_o low
//  result  | horz_*, vert_*                          | done_o, one cycle, no stall
//  config  | cfg_idx_i, cfg_data_i                   | cfg_we_i, any cycle idle
//
// A write item (func 0) stores one map cell at accept; busy_o stays low. A cast item
// runs the CORDIC (load and 24 rotations), then the divider for tan and then for cot
// (start, one quotient bit a cycle or early saturation, done), then the setup
// multiplies, then per walk a check of each touch point, which ends the walk when the
// point leaves the map or falls past its edge and else reads the map through the
// registered RAM port, and last the result strobe.
// Reset: map_cols and map_rows return to 64; the map itself is not cleared.
// The receiver cannot stall: done_o is high for exactly one cycle.
module grid_ray_wall_intersection import grwi_pkg::*; #(
  parameter int MAP_SIDE = MAP_SIDE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 func_i,
  input  logic [5:0]           cell_col_i,
  input  logic [5:0]           cell_row_i,
  input  logic [CODE_W-1:0]    cell_value_i,
  input  logic [COORD_W-1:0]   player_x_i,
  input  logic [COORD_W-1:0]   player_y_i,
  input  logic [ANG_W-1:0]     ray_angle_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 done_o,
  output logic                 horz_found_o,
  output logic [COORD_W-1:0]   horz_hit_x_o,
  output logic [COORD_W-1:0]   horz_hit_y_o,
  output logic [CODE_W-1:0]    horz_content_o,
  output logic                 vert_found_o,
  output logic [COORD_W-1:0]   vert_hit_x_o,
  output logic [COORD_W-1:0]   vert_hit_y_o,
  output logic [CODE_W-1:0]    vert_content_o
);

  localparam int ADDR_W = $clog2(MAP_SIDE * MAP_SIDE);
  localparam int IDX_W  = WALK_W - TILE_SHIFT;
  localparam logic signed [WALK_W-1:0] TFX = WALK_W'(1) <<< TILE_SHIFT;
  localparam logic signed [WALK_W-1:0] PIX = WALK_W'(1) <<< FRAC_BITS;

  grwi_state_e state_q, state_d;

  logic [CFG_W-1:0] map_cols_q, map_rows_q;
  logic [CFG_W-1:0] cols_eff, rows_eff;

  logic [COORD_W-1:0] px_q, py_q;
  logic               down_q, right_q, vert_q;
  logic signed [RATIO_W-1:0] tan_q, cot_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [WALK_W-1:0]  wx_q, wy_q, sx_q, sy_q;

  logic accept, cast_go, cordic_start, cordic_done, div_start, div_done;
  logic signed [CS_W-1:0]    cor_c, cor_s, div_num, div_den;
  logic signed [RATIO_W-1:0] div_q;

  logic signed [WALK_W-1:0] pxs, pys, base_x, base_y, probe_x, probe_y;
  logic signed [WALK_W-1:0] xmax, ymax, step_h, step_v;
  logic [IDX_W-1:0]  pcol, prow;
  logic              inb, past_edge, is_wall;
  logic [ADDR_W-1:0] waddr, raddr;
  logic              wr_en;
  logic [CODE_W-1:0] rdata;

  assign accept  = start_i && !busy_o;
  assign cast_go = accept && (func_i == FUNC_CAST);

  // bounds in use, saturated to the map size
  assign cols_eff = (32'(map_cols_q) > MAP_SIDE) ? CFG_W'(MAP_SIDE) : map_cols_q;
  assign rows_eff = (32'(map_rows_q) > MAP_SIDE) ? CFG_W'(MAP_SIDE) : map_rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_cols_q <= CFG_W'(64);
      map_rows_q <= CFG_W'(64);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_COLS) begin
        map_cols_q <= cfg_data_i;
      end else if (cfg_idx_i == CFG_ROWS) begin
        map_rows_q <= cfg_data_i;
      end
    end
  end

  // map write on accept of a write item; out-of-map cells are dropped
  assign wr_en = accept && (func_i == FUNC_WRITE) &&
                 (32'(cell_col_i) < MAP_SIDE) && (32'(cell_row_i) < MAP_SIDE);
  assign waddr = ADDR_W'(32'(cell_row_i) * MAP_SIDE + 32'(cell_col_i));

  grwi_ram #(.WIDTH(CODE_W), .DEPTH(MAP_SIDE * MAP_SIDE)) u_map (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (cell_value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  grwi_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (ray_angle_i),
    .done_o  (cordic_done),
    .c_o     (cor_c),
    .s_o     (cor_s)
  );

  // one divider serves tan = s/c, then cot = c/s
  assign div_num = (state_q == S_DIVC_GO) ? cor_c : cor_s;
  assign div_den = (state_q == S_DIVC_GO) ? cor_s : cor_c;

  grwi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // walk datapath
  always_comb begin
    pxs = $signed(WALK_W'(px_q));
    pys = $signed(WALK_W'(py_q));
    base_x = $signed({pxs[WALK_W-1:TILE_SHIFT], {TILE_SHIFT{1'b0}}}) +
             (right_q ? TFX : '0);
    base_y = $signed({pys[WALK_W-1:TILE_SHIFT], {TILE_SHIFT{1'b0}}}) +
             (down_q ? TFX : '0);
    // tile step scaled by cot / tan, sign forced to follow the facing
    step_h = WALK_W'(cot_q >>> (TRIG_FRAC - TILE_SHIFT));
    if ((!right_q && step_h > 0) || (right_q && step_h < 0)) begin
      step_h = -step_h;
    end
    step_v = WALK_W'(tan_q >>> (TRIG_FRAC - TILE_SHIFT));
    if ((!down_q && step_v > 0) || (down_q && step_v < 0)) begin
      step_v = -step_v;
    end
    // probe point: one pixel back for upward / leftward walks
    probe_x = wx_q - ((vert_q && !right_q) ? PIX : '0);
    probe_y = wy_q - ((!vert_q && !down_q) ? PIX : '0);
    xmax = $signed(WALK_W'(cols_eff)) <<< TILE_SHIFT;
    ymax = $signed(WALK_W'(rows_eff)) <<< TILE_SHIFT;
    inb = (wx_q >= 0) && (wx_q <= xmax) && (wy_q >= 0) && (wy_q <= ymax);
    pcol = probe_x[WALK_W-1:TILE_SHIFT];
    prow = probe_y[WALK_W-1:TILE_SHIFT];
    past_edge = (probe_x < 0) || (probe_y < 0) ||
                (pcol >= IDX_W'(cols_eff)) || (prow >= IDX_W'(rows_eff));
    raddr = ADDR_W'(32'(prow) * MAP_SIDE + 32'(pcol));
    is_wall = (rdata == CODE_WALL1) || (rdata == CODE_WALL2);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (cast_go) state_d = S_TRIG;
      S_TRIG:    if (cordic_done) state_d = S_DIVT_GO;
      S_DIVT_GO: state_d = S_DIVT;
      S_DIVT:    if (div_done) state_d = S_DIVC_GO;
      S_DIVC_GO: state_d = S_DIVC;
      S_DIVC:    if (div_done) state_d = S_MULH;
      S_MULH:    state_d = S_INITH;
      S_INITH:   state_d = S_CHK;
      S_CHK: begin
        if (!inb || past_edge) begin
          state_d = vert_q ? S_DONE : S_MULV;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (is_wall) begin
          state_d = vert_q ? S_DONE : S_MULV;
        end else begin
          state_d = S_CHK;
        end
      end
      S_MULV:    state_d = S_INITV;
      S_INITV:   state_d = S_CHK;
      S_DONE:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy_o       = (state_q != S_IDLE);
    done_o       = (state_q == S_DONE);
    cordic_start = cast_go;
    div_start    = (state_q == S_DIVT_GO) || (state_q == S_DIVC_GO);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vert_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_INITH) vert_q <= 1'b0;
      if (state_q == S_INITV) vert_q <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (cast_go) begin
          px_q    <= player_x_i;
          py_q    <= player_y_i;
          down_q  <= (ray_angle_i != '0) && (32'(ray_angle_i) < ANGLE_STEPS / 2);
          right_q <= (32'(ray_angle_i) < ANGLE_STEPS / 4) ||
                     (32'(ray_angle_i) > 3 * ANGLE_STEPS / 4);
        end
      end
      S_DIVT: if (div_done) tan_q <= div_q;
      S_DIVC: if (div_done) cot_q <= div_q;
      S_MULH: begin
        prod_q <= (base_y - pys) * cot_q;
        wy_q   <= base_y;
        sy_q   <= down_q ? TFX : -TFX;
        sx_q   <= step_h;
      end
      S_INITH: begin
        wx_q           <= pxs + WALK_W'(prod_q >>> TRIG_FRAC);
        horz_found_o   <= 1'b0;
        horz_hit_x_o   <= '0;
        horz_hit_y_o   <= '0;
        horz_content_o <= '0;
      end
      S_MULV: begin
        prod_q <= (base_x - pxs) * tan_q;
        wx_q   <= base_x;
        sx_q   <= right_q ? TFX : -TFX;
        sy_q   <= step_v;
      end
      S_INITV: begin
        wy_q           <= pys + WALK_W'(prod_q >>> TRIG_FRAC);
        vert_found_o   <= 1'b0;
        vert_hit_x_o   <= '0;
        vert_hit_y_o   <= '0;
        vert_content_o <= '0;
      end
      S_CHK: begin
        if (inb && past_edge) begin
          if (vert_q) begin
            vert_found_o   <= 1'b1;
            vert_hit_x_o   <= wx_q[COORD_W-1:0];
            vert_hit_y_o   <= wy_q[COORD_W-1:0];
            vert_content_o <= CODE_WALL1;
          end else begin
            horz_found_o   <= 1'b1;
            horz_hit_x_o   <= wx_q[COORD_W-1:0];
            horz_hit_y_o   <= wy_q[COORD_W-1:0];
            horz_content_o <= CODE_WALL1;
          end
        end
      end
      S_RD: begin
        if (is_wall) begin
          if (vert_q) begin
            vert_found_o   <= 1'b1;
            vert_hit_x_o   <= wx_q[COORD_W-1:0];
            vert_hit_y_o   <= wy_q[COORD_W-1:0];
            vert_content_o <= rdata;
          end else begin
            horz_found_o   <= 1'b1;
            horz_hit_x_o   <= wx_q[COORD_W-1:0];
            horz_hit_y_o   <= wy_q[COORD_W-1:0];
            horz_content_o <= rdata;
          end
        end else begin
          wx_q <= wx_q + sx_q;
          wy_q <= wy_q + sy_q;
        end
      end
      default: ;
    endcase
  end

  // result strobe lasts one cycle and frees the block
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o)
    else $error("result strobe longer than one cycle");

  // a result only ends a cast that was busy the cycle before
  a_done_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result without a cast");

  // a horizontal miss reports zero content and a zero hit x
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !horz_found_o |-> horz_content_o == '0 && horz_hit_x_o == '0)
    else $error("horizontal miss with nonzero fields");

endmodule

// ===== tb/grwi_checker.sv =====
// Checker for the grid ray / wall intersection block: predicts each cast and compares results.
`timescale 1ns / 1ps
module grwi_checker import grwi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic                 func_i,
  input  logic [5:0]           cell_col_i,
  input  logic [5:0]           cell_row_i,
  input  logic [CODE_W-1:0]    cell_value_i,
  input  logic [COORD_W-1:0]   player_x_i,
  input  logic [COORD_W-1:0]   player_y_i,
  input  logic [ANG_W-1:0]     ray_angle_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 done_i,
  input  logic                 horz_found_i,
  input  logic [COORD_W-1:0]   horz_hit_x_i,
  input  logic [COORD_W-1:0]   horz_hit_y_i,
  input  logic [CODE_W-1:0]    horz_content_i,
  input  logic                 vert_found_i,
  input  logic [COORD_W-1:0]   vert_hit_x_i,
  input  logic [COORD_W-1:0]   vert_hit_y_i,
  input  logic [CODE_W-1:0]    vert_content_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam longint TFX  = longint'(TILE) << FRAC_BITS;
  localparam longint PIX  = longint'(1) << FRAC_BITS;
  localparam longint TLIM = longint'(1) << 26;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] hx;
    logic [COORD_W-1:0] hy;
    logic [CODE_W-1:0]  code;
  } hit_t;

  typedef struct packed {
    hit_t horz;
    hit_t vert;
  } cast_t;

  logic [CODE_W-1:0] tiles [MAP_SIDE_DEF*MAP_SIDE_DEF];
  logic [CFG_W-1:0]  cols_q, rows_q;
  cast_t             expected_casts [$];

  assign pending_o = expected_casts.size();

  function automatic longint ratio_q16(longint num, longint den);
    logic   neg;
    longint an, ad, mag;
    neg = (num < 0) != (den < 0);
    an  = num < 0 ? -num : num;
    ad  = den < 0 ? -den : den;
    if (ad == 0) mag = TLIM;
    else begin
      mag = ((an << TRIG_FRAC) + ad / 2) / ad;
      if (mag > TLIM) mag = TLIM;
    end
    return neg ? -mag : mag;
  endfunction

  function automatic logic [CODE_W-1:0] tile_at(longint x, longint y, longint nc, longint nr);
    longint c, r;
    if (x < 0 || y < 0) return CODE_WALL1;
    c = x / TFX;
    r = y / TFX;
    if (c >= nc || r >= nr) return CODE_WALL1;
    return tiles[r*MAP_SIDE_DEF + c];
  endfunction

  function automatic hit_t march(longint wx, longint wy, longint sx, longint sy,
                                 longint offx, longint offy, longint nc, longint nr);
    hit_t              h;
    logic [CODE_W-1:0] code;
    h = '0;
    while (wx >= 0 && wx <= nc*TFX && wy >= 0 && wy <= nr*TFX) begin
      code = tile_at(wx + offx, wy + offy, nc, nr);
      if (code == CODE_WALL1 || code == CODE_WALL2) begin
        h.found = 1'b1;
        h.hx    = wx[COORD_W-1:0];
        h.hy    = wy[COORD_W-1:0];
        h.code  = code;
        return h;
      end
      wx += sx;
      wy += sy;
    end
    return h;
  endfunction

  function automatic cast_t predict_cast(longint px, longint py, longint a);
    cast_t  r;
    longint nc, nr, z, c, s, dc, ds, tq, cq, wx, wy, sx, sy;
    logic   down, right;
    nc    = cols_q > MAP_SIDE_DEF ? MAP_SIDE_DEF : cols_q;
    nr    = rows_q > MAP_SIDE_DEF ? MAP_SIDE_DEF : rows_q;
    down  = a > 0 && 2*a < ANGLE_STEPS;
    right = 4*a < ANGLE_STEPS || 4*a > 3*ANGLE_STEPS;
    // CORDIC in turn units, folded to within a quarter turn of zero
    z = (a << 32) / ANGLE_STEPS;
    c = longint'(1) << 30;
    s = 0;
    if (z >= (longint'(3) << 30)) z -= longint'(1) << 32;
    else if (z >= (longint'(1) << 30)) z -= longint'(1) << 31;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dc = s >>> i;
      ds = c >>> i;
      if (z >= 0) begin
        c -= dc; s += ds; z -= longint'(turn_atan(i[4:0]));
      end else begin
        c += dc; s -= ds; z += longint'(turn_atan(i[4:0]));
      end
    end
    tq = ratio_q16(s, c);
    cq = ratio_q16(c, s);
    // horizontal grid lines
    wy = (py / TFX) * TFX + (down ? TFX : 0);
    wx = px + (((wy - py) * cq) >>> TRIG_FRAC);
    sy = down ? TFX : -TFX;
    sx = (TFX * cq) >>> TRIG_FRAC;
    if ((!right && sx > 0) || (right && sx < 0)) sx = -sx;
    r.horz = march(wx, wy, sx, sy, 0, down ? 0 : -PIX, nc, nr);
    // vertical grid lines
    wx = (px / TFX) * TFX + (right ? TFX : 0);
    wy = py + (((wx - px) * tq) >>> TRIG_FRAC);
    sx = right ? TFX : -TFX;
    sy = (TFX * tq) >>> TRIG_FRAC;
    if ((!down && sy > 0) || (down && sy < 0)) sy = -sy;
    r.vert = march(wx, wy, sx, sy, right ? 0 : -PIX, 0, nc, nr);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    cast_t e;
    if (!rst_ni) begin
      cols_q <= 7'd64;
      rows_q <= 7'd64;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_COLS) cols_q <= cfg_data_i;
        else if (cfg_idx_i == CFG_ROWS) rows_q <= cfg_data_i;
      end
      if (start_i && !busy_i) begin
        if (func_i == FUNC_WRITE) tiles[{cell_row_i, cell_col_i}] = cell_value_i;
        else expected_casts.push_back(predict_cast(player_x_i, player_y_i, ray_angle_i));
      end
      if (done_i) begin
        if (expected_casts.size() == 0) report_mismatch("unexpected result", 1, 0);
        else begin
          e = expected_casts.pop_front();
          if (horz_found_i   !== e.horz.found) report_mismatch("horz_found", horz_found_i, e.horz.found);
          if (horz_hit_x_i   !== e.horz.hx)    report_mismatch("horz_hit_x", horz_hit_x_i, e.horz.hx);
          if (horz_hit_y_i   !== e.horz.hy)    report_mismatch("horz_hit_y", horz_hit_y_i, e.horz.hy);
          if (horz_content_i !== e.horz.code)  report_mismatch("horz_content", horz_content_i, e.horz.code);
          if (vert_found_i   !== e.vert.found) report_mismatch("vert_found", vert_found_i, e.vert.found);
          if (vert_hit_x_i   !== e.vert.hx)    report_mismatch("vert_hit_x", vert_hit_x_i, e.vert.hx);
          if (vert_hit_y_i   !== e.vert.hy)    report_mismatch("vert_hit_y", vert_hit_y_i, e.vert.hy);
          if (vert_content_i !== e.vert.code)  report_mismatch("vert_content", vert_content_i, e.vert.code);
        end
      end
    end
  end

endmodule

// ===== tb/grid_ray_wall_intersection_tb.sv =====
// Testbench top: drives map writes, configuration and ray casts into the block.
`timescale 1ns / 1ps
module grid_ray_wall_intersection_tb import grwi_pkg::*; ();

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic                 func_i = FUNC_WRITE;
  logic [5:0]           cell_col_i = '0;
  logic [5:0]           cell_row_i = '0;
  logic [CODE_W-1:0]    cell_value_i = '0;
  logic [COORD_W-1:0]   player_x_i = '0;
  logic [COORD_W-1:0]   player_y_i = '0;
  logic [ANG_W-1:0]     ray_angle_i = '0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_COLS;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 done_o;
  logic                 horz_found_o, vert_found_o;
  logic [COORD_W-1:0]   horz_hit_x_o, horz_hit_y_o, vert_hit_x_o, vert_hit_y_o;
  logic [CODE_W-1:0]    horz_content_o, vert_content_o;
  int                   fail_count, pending;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  grid_ray_wall_intersection DUT (.*);

  grwi_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .func_i, .cell_col_i, .cell_row_i,
    .cell_value_i, .player_x_i, .player_y_i, .ray_angle_i, .cfg_we_i, .cfg_idx_i,
    .cfg_data_i, .done_i(done_o), .horz_found_i(horz_found_o), .horz_hit_x_i(horz_hit_x_o),
    .horz_hit_y_i(horz_hit_y_o), .horz_content_i(horz_content_o),
    .vert_found_i(vert_found_o), .vert_hit_x_i(vert_hit_x_o), .vert_hit_y_i(vert_hit_y_o),
    .vert_content_i(vert_content_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  int burst_left = 0;

  // Offer one item; start stays high across back-to-back items in a burst.
  // Every input change happens on the falling edge, accept is on the next rising edge.
  task automatic offer(logic fn, logic [5:0] c, logic [5:0] r, logic [7:0] v,
                       logic [COORD_W-1:0] px, logic [COORD_W-1:0] py, logic [ANG_W-1:0] ang);
    // the previous item, if any, went in at the rising edge just passed
    @(negedge clk_i);
    if (burst_left == 0) begin
      start_i = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 20) : 0) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    while (busy_o) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i      = 1'b1;
    func_i       = fn;
    cell_col_i   = c;
    cell_row_i   = r;
    cell_value_i = v;
    player_x_i   = px;
    player_y_i   = py;
    ray_angle_i  = ang;
    burst_left--;
  endtask

  task automatic put_tile(logic [5:0] c, logic [5:0] r, logic [7:0] v);
    offer(FUNC_WRITE, c, r, v, COORD_W'($urandom), COORD_W'($urandom), ANG_W'($urandom));
  endtask

  task automatic cast(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py, logic [ANG_W-1:0] ang);
    offer(FUNC_CAST, 6'($urandom), 6'($urandom), 8'($urandom), px, py, ang);
  endtask

  // Random map content: mostly floor, some walls of both kinds, some other codes.
  function automatic logic [7:0] rand_code();
    case ($urandom_range(0, 9))
      0, 1:    return CODE_WALL1;
      2:       return CODE_WALL2;
      3:       return 8'($urandom);
      default: return 8'h30;
    endcase
  endfunction

  // Wait for the block to drain, so that a caller can write a register while idle.
  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    burst_left = 0;
    while (pending != 0 || busy_o) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  task automatic set_bounds(logic [CFG_W-1:0] nc, logic [CFG_W-1:0] nr);
    drain();
    cfg_we_i   = 1'b1;
    cfg_idx_i  = CFG_COLS;
    cfg_data_i = nc;
    @(negedge clk_i);
    cfg_idx_i  = CFG_ROWS;
    cfg_data_i = nr;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  // Mostly inside the active map, now and then anywhere in the 21-bit range.
  function automatic logic [COORD_W-1:0] rand_pos(int span);
    if ($urandom_range(0, 9) == 0) return COORD_W'($urandom);
    return COORD_W'($urandom_range(0, span * TILE * 256 + 300));
  endfunction

  logic [ANG_W-1:0] edge_angles [14] = '{0, 1, 1023, 1024, 1025, 2047, 2048, 2049,
                                          3071, 3072, 3073, 4095, 512, 2560};

  initial begin
    int nc, nr;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // rows 0..3 across the full width and columns 0..3 down the full height;
    // every bound pair below keeps one side at four tiles or less, so each
    // map read lands on a written cell
    for (int r = 0; r < MAP_SIDE_DEF; r++)
      for (int c = 0; c < MAP_SIDE_DEF; c++)
        if (r < 4 || c < 4) put_tile(6'(c), 6'(r), rand_code());

    // directed: facing boundaries, corners of the coordinate range, edge bounds
    set_bounds(7'd127, 7'd4);
    foreach (edge_angles[i]) cast(21'd40000, 21'd30000, edge_angles[i]);
    cast('0, '0, 12'd512);
    cast(21'h1FFFFF, 21'h1FFFFF, 12'd2560);
    cast(21'd1048576, 21'd1048576, 12'd2560);
    cast(21'd16384, 21'd16384, 12'd3584);
    set_bounds(7'd4, 7'd127);
    cast(21'd30000, 21'd40000, 12'd1000);
    cast(21'd30000, 21'd900000, 12'd3000);
    set_bounds(7'd0, 7'd0);
    cast(21'd100, 21'd100, 12'd300);
    set_bounds(7'd1, 7'd1);
    cast(21'd8000, 21'd8000, 12'd1500);
    cast(21'd8000, 21'd8000, 12'd3500);
    set_bounds(7'd4, 7'd4);
    cast(21'd50000, 21'd60000, 12'd777);
    cast(21'd50000, 21'd60000, 12'd2900);

    // random phases with a new map size each; the wall codes get rewritten as we go
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 2 == 1) begin
        nc = $urandom_range(0, 4);
        nr = $urandom_range(0, 127);
      end else begin
        nc = $urandom_range(0, 127);
        nr = $urandom_range(0, 4);
      end
      set_bounds(CFG_W'(nc), CFG_W'(nr));
      for (int n = 0; n < 60; n++) begin
        if ($urandom_range(0, 3) == 0) put_tile(6'($urandom), 6'($urandom), rand_code());
        else if ($urandom_range(0, 4) == 0)
          cast(rand_pos(64), rand_pos(64), edge_angles[$urandom_range(0, 13)]);
        else cast(rand_pos(nc > 64 ? 64 : nc), rand_pos(nr > 64 ? 64 : nr), ANG_W'($urandom));
      end
    end

    drain();
    repeat (400) @(posedge clk_i);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/grwi_pkg.sv
sv/grwi_ram.sv
sv/grwi_cordic.sv
sv/grwi_div.sv
sv/grid_ray_wall_intersection.sv
tb/grwi_checker.sv
tb/grid_ray_wall_intersection_tb.sv
